// ===== sv/bbrf_pkg.sv =====
// Package for the burst byte ring FIFO: sizes, operation and status codes,
// the port structs of the byte store and the ring arithmetic helpers.
// Depends on nothing; every other file imports it.
package bbrf_pkg;

   // Bytes in the store. Widths of the indexes and counters follow from it.
   localparam int DEPTH    = 64;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int FIELD_W  = 7;
   localparam int CMP_W    = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
   localparam int MAX_READ = 64;
   localparam logic [FIELD_W-1:0] SIZE_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_SPACE = 2'd1,
      STAT_NO_DATA  = 2'd2,
      STAT_UNUSED   = 2'd3
   } status_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } store_rd_type;

   // Ring size from the register value: zero acts as one, too large as DEPTH.
   function automatic logic [CNT_W-1:0] ring_clamp(input logic [FIELD_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (CMP_W'(v) > CMP_W'(DEPTH)) begin
         r = CNT_W'(DEPTH);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] free_of(input logic [CNT_W-1:0] sz,
                                                 input logic [CNT_W-1:0] held);
      return (held >= sz) ? '0 : sz - held;
   endfunction

   // Step an index by one and wrap it at the ring size.
   function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] idx,
                                                    input logic [CNT_W-1:0]  sz);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(idx) + CNT_W'(1);
      return (nxt >= sz) ? '0 : ADDR_W'(nxt);
   endfunction

endpackage

// ===== sv/bbrf_store.sv =====
// Byte store of the ring FIFO: one write port, one read port, registered
// read data that holds while no read is issued. Depends on bbrf_pkg.
module bbrf_store
   import bbrf_pkg::*;
(
   input  logic         clock,
   input  store_wr_type wr,
   input  store_rd_type rd,
   output logic [7:0]   rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/burst_byte_ring_fifo.sv =====
// Burst byte ring FIFO, top level. A result beat passes through stage one, which
// loads when its request beat is accepted, and then the output register. Throughput:
// one beat per cycle for write, clear and failed reads while stage one can move; a read
// burst streams one store read per cycle while stage one moves (single read port).
// Reset (synchronous, active high) empties the ring, ends any burst and sets
// the size in use to 64; the byte store itself is not cleared.
module burst_byte_ring_fifo
   import bbrf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_op,
   input  logic [6:0]   req_count,
   input  logic [7:0]   req_data,
   // Response channel.
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [1:0]   rsp_status,
   output logic [7:0]   rsp_read_byte,
   output logic [6:0]   rsp_used_count,
   output logic [6:0]   rsp_free_count,
   output logic         rsp_last,
   // Size register write port.
   input  logic         csr_write_en,
   input  logic [6:0]   csr_write_data
);

   // The sequencer is idle between requests and busy while a read burst is
   // still streaming bytes out of the store.
   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_READ = 2'b10
   } fsm_type;

   // Ring state.
   fsm_type           state_ff, state_in;
   logic [CNT_W-1:0]  sz_ff, sz_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic [6:0]        burst_rem_ff, burst_rem_in;
   logic              burst_adm_ff, burst_adm_in;
   logic [6:0]        rd_left_ff, rd_left_in;

   // Stage one holds a result whose byte, if any, is arriving from the store.
   logic              s1_valid_ff;
   logic              s1_load;
   status_type        s1_status_ff, s1_status_in;
   logic              s1_is_rd_ff, s1_is_rd_in;
   logic [6:0]        s1_used_ff, s1_used_in;
   logic [6:0]        s1_free_ff, s1_free_in;
   logic              s1_last_ff, s1_last_in;

   // Output register.
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [7:0]        rsp_read_byte_ff;
   logic [6:0]        rsp_used_ff;
   logic [6:0]        rsp_free_ff;
   logic              rsp_last_ff;

   store_wr_type      st_wr;
   store_rd_type      st_rd;
   logic [7:0]        st_rd_data;

   logic              load_out;
   logic              adv1;
   logic              accept;
   op_type            op;
   logic [CNT_W-1:0]  free_now;
   logic              wr_first;
   logic              wr_adm;
   logic              rd_go;
   logic [6:0]        rd_n;

   bbrf_store u_store (
      .clock   (clock),
      .wr      (st_wr),
      .rd      (st_rd),
      .rd_data (st_rd_data)
   );

   // The output register loads whenever it is empty or being drained, and
   // stage one moves whenever the output register can take its contents.
   assign load_out = !rsp_valid_ff || rsp_ready;
   assign adv1     = !s1_valid_ff || load_out;

   // New requests are taken only between read bursts. This is also the
   // interlock on the store: no write can meet a read of the same byte,
   // because every byte read was written in an earlier cycle.
   assign req_ready = (state_ff == FSM_IDLE) && adv1;
   assign accept    = req_valid && req_ready;
   assign op        = op_type'(req_op);
   assign free_now  = free_of(sz_ff, held_ff);
   assign wr_first  = (burst_rem_ff == '0);

   always_comb begin
      state_in     = state_ff;
      sz_in        = sz_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      held_in      = held_ff;
      burst_rem_in = burst_rem_ff;
      burst_adm_in = burst_adm_ff;
      rd_left_in   = rd_left_ff;
      s1_load      = 1'b0;
      s1_status_in = STAT_OK;
      s1_is_rd_in  = 1'b0;
      s1_last_in   = 1'b1;
      st_wr        = '0;
      st_rd        = '0;
      wr_adm       = 1'b0;
      rd_go        = 1'b0;
      rd_n         = rd_left_ff;

      if (csr_write_en) begin
         // A new size empties the ring and drops any burst in progress.
         sz_in        = ring_clamp(csr_write_data);
         head_in      = '0;
         tail_in      = '0;
         held_in      = '0;
         burst_rem_in = '0;
         burst_adm_in = 1'b0;
         state_in     = FSM_IDLE;
      end else if (state_ff == FSM_READ) begin
         rd_go = adv1;
      end else if (accept) begin
         s1_load = 1'b1;
         case (op)
            OP_WRITE: begin
               if (wr_first && req_count == '0) begin
                  // An empty burst stores nothing and starts nothing.
                  s1_status_in = STAT_OK;
               end else begin
                  // The first beat of a burst decides whether the whole burst
                  // fits; the following beats reuse that decision.
                  wr_adm = wr_first ? (CMP_W'(req_count) <= CMP_W'(free_now))
                                    : burst_adm_ff;
                  burst_adm_in = wr_adm;
                  burst_rem_in = (wr_first ? req_count : burst_rem_ff) - 7'd1;
                  if (wr_adm && held_ff < sz_ff) begin
                     st_wr.en     = 1'b1;
                     st_wr.addr   = head_ff;
                     st_wr.data   = req_data;
                     head_in      = ring_next(head_ff, sz_ff);
                     held_in      = held_ff + CNT_W'(1);
                     s1_status_in = STAT_OK;
                  end else begin
                     s1_status_in = STAT_NO_SPACE;
                  end
               end
            end
            OP_READ: begin
               if (req_count == '0) begin
                  s1_status_in = STAT_OK;
               end else if (CMP_W'(req_count) > CMP_W'(held_ff) ||
                            CMP_W'(req_count) > CMP_W'(MAX_READ)) begin
                  // A short read fails whole and leaves the ring untouched.
                  s1_status_in = STAT_NO_DATA;
               end else begin
                  s1_load = 1'b0;
                  rd_go   = 1'b1;
                  rd_n    = req_count;
               end
            end
            OP_CLEAR: begin
               head_in      = '0;
               tail_in      = '0;
               held_in      = '0;
               burst_rem_in = '0;
               burst_adm_in = 1'b0;
               s1_status_in = STAT_OK;
            end
            default: begin
               s1_status_in = STAT_OK;
            end
         endcase
      end

      // One byte of a read burst leaves the tail: the first one in the cycle
      // the request is taken, the rest one per cycle while stage one moves.
      if (rd_go) begin
         st_rd.en     = 1'b1;
         st_rd.addr   = tail_ff;
         tail_in      = ring_next(tail_ff, sz_ff);
         held_in      = held_ff - CNT_W'(1);
         rd_left_in   = rd_n - 7'd1;
         s1_load      = 1'b1;
         s1_status_in = STAT_OK;
         s1_is_rd_in  = 1'b1;
         s1_last_in   = (rd_n == 7'd1);
         state_in     = (rd_n == 7'd1) ? FSM_IDLE : FSM_READ;
      end

      // Every result reports the counts as they stand after it.
      s1_used_in = FIELD_W'(held_in);
      s1_free_in = FIELD_W'(free_of(sz_ff, held_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         sz_ff        <= ring_clamp(SIZE_RESET);
         head_ff      <= '0;
         tail_ff      <= '0;
         held_ff      <= '0;
         burst_rem_ff <= '0;
         burst_adm_ff <= 1'b0;
         rd_left_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sz_ff        <= sz_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         held_ff      <= held_in;
         burst_rem_ff <= burst_rem_in;
         burst_adm_ff <= burst_adm_in;
         rd_left_ff   <= rd_left_in;
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (load_out) begin
            s1_valid_ff <= 1'b0;
         end
         if (load_out) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_status_ff <= s1_status_in;
         s1_is_rd_ff  <= s1_is_rd_in;
         s1_used_ff   <= s1_used_in;
         s1_free_ff   <= s1_free_in;
         s1_last_ff   <= s1_last_in;
      end
      if (load_out) begin
         rsp_status_ff    <= s1_status_ff;
         rsp_read_byte_ff <= s1_is_rd_ff ? st_rd_data : 8'd0;
         rsp_used_ff      <= s1_used_ff;
         rsp_free_ff      <= s1_free_ff;
         rsp_last_ff      <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_byte  = rsp_read_byte_ff;
   assign rsp_used_count = rsp_used_ff;
   assign rsp_free_count = rsp_free_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTHESIS
   // The ring never holds more bytes than its size.
   a_held_in_size: assert property (@(posedge clock) disable iff (reset)
      held_ff <= sz_ff)
      else $error("held count exceeds ring size");

   // A read burst in progress always has its remaining bytes in the ring.
   a_read_covered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_READ) |-> (CMP_W'(rd_left_ff) <= CMP_W'(held_ff)))
      else $error("read burst runs past the held bytes");

   // A stage-one result is never lost while the output register is stalled.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !load_out) |=> s1_valid_ff)
      else $error("stage one result dropped under stall");

   // No request is taken while a read burst is streaming.
   a_no_req_in_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_READ) |-> !req_ready)
      else $error("request taken during read burst");
`endif

endmodule
